FILE: sv/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned OpW          = 3;
  localparam int unsigned WordW        = 32;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LOOK       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_APPLY = 2'd1,
    ST_READ  = 2'd2,
    ST_RESP  = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic apply;
    logic read;
    logic respond;
  } dq_cmd_t;

endpackage

FILE: sv/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output dq_pkg::dq_cmd_t cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_READ;
      ST_READ:  state_d = ST_RESP;
      ST_RESP:  state_d = start ? ST_APPLY : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_RESP: begin
        busy          = 1'b0;
        cmd_o.respond = 1'b1;
        cmd_o.capture = start;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dq_pkg::dq_cmd_t                   cmd_i,
  input  logic        [dq_pkg::OpW-1:0]     op_i,
  input  logic signed [dq_pkg::WordW-1:0]   value_i,
  output logic signed [dq_pkg::WordW-1:0]   front_value_o,
  output logic signed [dq_pkg::WordW-1:0]   back_value_o,
  output logic                              empty_o,
  output logic        [CntW-1:0]            entry_count_o,
  output logic                              overflow_o
);
  import dq_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned SumW  = AddrW + 1;

  logic [WordW-1:0] word_mem [DEPTH];

  logic [OpW-1:0]   op_q;
  logic [WordW-1:0] value_q;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [WordW-1:0] front_q, back_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] head_dec, head_inc, tail_idx, back_idx;
  logic [SumW-1:0]  tail_sum;
  logic             full, empty;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? AddrW'(DEPTH - 1) : head_q - AddrW'(1);
  assign head_inc = (head_q == AddrW'(DEPTH - 1)) ? '0 : head_q + AddrW'(1);

  // Slot just past the back word, wrapped into the circular store.
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= SumW'(DEPTH)) ? AddrW'(tail_sum - SumW'(DEPTH))
                                               : AddrW'(tail_sum);
  assign back_idx = (tail_idx == '0) ? AddrW'(DEPTH - 1) : tail_idx - AddrW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_addr = tail_idx;
    if (cmd_i.apply) begin
      ovf_d = 1'b0;
      case (op_e'(op_q))
        OP_PUSH_FRONT: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            head_d  = head_dec;
            wr_en   = 1'b1;
            wr_addr = head_dec;
            count_d = count_q + CntW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tail_idx;
            count_d = count_q + CntW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          ovf_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_mem[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      front_q <= word_mem[head_q];
      back_q  <= word_mem[back_idx];
    end
  end

  assign empty_o       = empty;
  assign front_value_o = empty ? '0 : $signed(front_q);
  assign back_value_o  = empty ? '0 : $signed(back_q);
  assign entry_count_o = count_q;
  assign overflow_o    = ovf_q;

endmodule

FILE: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// A request accepted at a clock edge passes through the apply, read and respond states; its
// result is on the outputs, with done_o high, in the respond state, and is taken there.
// A new request is taken only in the idle or respond state, after the apply, read and respond
// steps around the single write port and the registered reads of the word memory.
// Reset clears the head index, the count and the controller; the memory is not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic        [dq_pkg::OpW-1:0]     op_i,
  input  logic signed [dq_pkg::WordW-1:0]   value_i,
  output logic                              done_o,
  output logic signed [dq_pkg::WordW-1:0]   front_value_o,
  output logic signed [dq_pkg::WordW-1:0]   back_value_o,
  output logic                              empty_o,
  output logic        [CntW-1:0]            entry_count_o,
  output logic                              overflow_o
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH),
    .CntW  (CntW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .value_i       (value_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .empty_o       (empty_o),
    .entry_count_o (entry_count_o),
    .overflow_o    (overflow_o)
  );

  assign done_o = cmd.respond;

endmodule

FILE: sv/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic signed [dq_pkg::WordW-1:0] front_value_o,
  input logic signed [dq_pkg::WordW-1:0] back_value_o,
  input logic                            empty_o,
  input logic        [CntW-1:0]          entry_count_o,
  input logic                            overflow_o
);

  // Every accepted request produces its result, with done_o high, in the respond state.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result did not follow request after three cycles");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty deque reported nonzero words");

  // A dropped push can only happen when the store is full.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (entry_count_o == CntW'(DEPTH)))
    else $error("overflow reported while store not full");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH),
  .CntW  (CntW)
) u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .empty_o       (empty_o),
  .entry_count_o (entry_count_o),
  .overflow_o    (overflow_o)
);

FILE: tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int unsigned DEPTH = DefaultDepth;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [OpW-1:0] OpSpareFirst = 3'd5;
  localparam logic [OpW-1:0] OpSpareLast = 3'd7;
  localparam int unsigned RandomRequests = 700;

  typedef struct {
    logic [WordW-1:0] front;
    logic [WordW-1:0] back;
    logic             empty;
    logic [CntW-1:0]  count;
    logic             dropped;
  } deque_status_t;

  class deque_mirror;
    logic [WordW-1:0] words[DEPTH];
    int unsigned      head;
    int unsigned      held;
    deque_status_t    awaited_status[$];
    int unsigned      mismatches;

    function new();
      head = 0;
      held = 0;
      mismatches = 0;
    endfunction

    function void apply_request(logic [OpW-1:0] op, logic [WordW-1:0] word);
      deque_status_t st;
      st.dropped = 1'b0;
      case (op)
        OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            st.dropped = 1'b1;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            words[head] = word;
            held++;
          end
        end
        OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            st.dropped = 1'b1;
          end else begin
            words[(head + held) % DEPTH] = word;
            held++;
          end
        end
        OP_POP_FRONT: begin
          if (held > 0) begin
            head = (head + 1) % DEPTH;
            held--;
          end
        end
        OP_POP_BACK: begin
          if (held > 0) held--;
        end
        default: ;
      endcase
      if (held == 0) begin
        st.front = '0;
        st.back = '0;
        st.empty = 1'b1;
      end else begin
        st.front = words[head];
        st.back = words[(head + held - 1) % DEPTH];
        st.empty = 1'b0;
      end
      st.count = held[CntW-1:0];
      awaited_status.insert(awaited_status.size(), st);
    endfunction

    function bit field_differs(string name, logic [WordW-1:0] exp, logic [WordW-1:0] act);
      if (act === exp) return 1'b0;
      $error("%s mismatch: expected 0x%h, actual 0x%h", name, exp, act);
      return 1'b1;
    endfunction

    function void check_result(logic [WordW-1:0] front, logic [WordW-1:0] back,
                               logic empty, logic [CntW-1:0] count, logic dropped);
      deque_status_t st;
      bit bad;
      if (awaited_status.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      st = awaited_status[0];
      awaited_status.delete(0);
      bad = field_differs("front_value", st.front, front);
      bad |= field_differs("back_value", st.back, back);
      bad |= field_differs("empty", WordW'(st.empty), WordW'(empty));
      bad |= field_differs("entry_count", WordW'(st.count), WordW'(count));
      bad |= field_differs("overflow", WordW'(st.dropped), WordW'(dropped));
      if (bad) mismatches++;
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [OpW-1:0]          op_i;
  logic signed [WordW-1:0] value_i;
  logic                    done_o;
  logic signed [WordW-1:0] front_value_o;
  logic signed [WordW-1:0] back_value_o;
  logic                    empty_o;
  logic [CntW-1:0]         entry_count_o;
  logic                    overflow_o;

  deque_mirror mirror = new();
  bit          steady;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .empty_o      (empty_o),
    .entry_count_o(entry_count_o),
    .overflow_o   (overflow_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      mirror.check_result(front_value_o, back_value_o, empty_o, entry_count_o,
                          overflow_o);
    end
  end

  task automatic issue_request(input logic [OpW-1:0] op, input logic [WordW-1:0] word);
    while (!steady && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    value_i <= word;
    do @(posedge clk_i); while (busy !== 1'b0);
    mirror.apply_request(op, word);
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_push();
    return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic logic [OpW-1:0] pick_pop();
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  function automatic logic [OpW-1:0] pick_op(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return pick_push();
    if (roll < 94) return pick_pop();
    if (roll < 97) return OP_LOOK;
    return OpW'($urandom_range(OpSpareLast, OpSpareFirst));
  endfunction

  function automatic int unsigned pick_push_bias();
    case ($urandom_range(2))
      0: return 80;
      1: return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned bias;
    int unsigned waited;
    rst_ni = 1'b0;
    start = 1'b0;
    op_i = OP_LOOK;
    value_i = '0;
    steady = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque: looks, pops that must be ignored and the spare op codes, then pushes and pops.
    issue_request(OP_LOOK, '0);
    issue_request(OP_POP_FRONT, 32'h1234_5678);
    issue_request(OP_POP_BACK, '1);
    for (int k = OpSpareFirst; k <= OpSpareLast; k++) issue_request(OpW'(k), $urandom());
    issue_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    issue_request(OP_PUSH_BACK, 32'h8000_0000);
    issue_request(OP_LOOK, '0);
    issue_request(OP_PUSH_FRONT, '0);
    issue_request(OP_PUSH_BACK, '1);
    issue_request(OpSpareLast, 32'hDEAD_BEEF);
    issue_request(OP_POP_FRONT, '0);
    issue_request(OP_POP_BACK, '0);
    issue_request(OP_POP_BACK, '0);
    issue_request(OP_POP_FRONT, '0);
    issue_request(OP_POP_FRONT, '0);
    issue_request(OP_PUSH_BACK, 32'h0000_0001);
    issue_request(OP_PUSH_FRONT, 32'h5555_5555);
    issue_request(OP_PUSH_BACK, 32'hAAAA_AAAA);
    issue_request(OP_POP_BACK, '0);
    issue_request(OP_POP_FRONT, '0);
    issue_request(OP_POP_FRONT, '0);

    // Fill to capacity so that every push beyond it is dropped, run a mixed stretch, then drain.
    while (mirror.held < DEPTH) issue_request(pick_push(), pick_word());
    repeat (4) issue_request(pick_push(), pick_word());
    issue_request(OP_LOOK, '0);
    repeat (40) issue_request(pick_op(50), pick_word());
    while (mirror.held > 0) issue_request(pick_pop(), pick_word());
    issue_request(OP_POP_BACK, '0);
    issue_request(OP_POP_FRONT, '0);

    sent = 0;
    while (sent < RandomRequests) begin
      seg_len = $urandom_range(40, 1);
      bias = pick_push_bias();
      for (int j = 0; j < seg_len; j++) begin
        steady = (sent >= 250 && sent < 450);
        issue_request(pick_op(bias), pick_word());
        sent++;
      end
    end
    steady = 1'b0;
    start <= 1'b0;

    waited = 0;
    while (mirror.awaited_status.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (mirror.awaited_status.size() != 0) begin
      $error("%0d requests never produced a result", mirror.awaited_status.size());
      mirror.mismatches++;
    end
    if (mirror.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
sv/dq_checker.sv
tb/sv/tb_double_ended_queue.sv
